/* design/bdrm_pkg.sv */
// Shared types, widths and constants for the battery drain rate monitor.
package bdrm_pkg;

   // Defaults for the top-level parameters.
   localparam int WINDOW_DEF       = 10;
   localparam int NUM_CHANNELS_DEF = 4;

   // Field widths.
   localparam int CHANNEL_W = 2;
   localparam int TIME_W    = 32;
   localparam int LEVEL_W   = 15;
   localparam int RATE_W    = 16;
   localparam int DEN_W     = 25;   // depletion * 1000 always fits
   localparam int PROD_W    = 48;   // 32 x 16 product
   localparam int STEP_W    = 5;    // counts the 16 quotient bits

   // Stream word layouts.
   localparam int REQ_FIELDS_W = CHANNEL_W + TIME_W + LEVEL_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = CHANNEL_W + RATE_W + 1 + RATE_W + RATE_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRITICAL  = 2'd1;
   localparam logic [RATE_W-1:0]      THRESHOLD_RST = 16'd384;
   localparam logic [LEVEL_W-1:0]     CRITICAL_RST  = 15'd5120;

   // Item kinds.
   localparam logic MODE_PUSH = 1'b0;

   // Arithmetic constants.
   localparam logic [RATE_W-1:0] MS_PER_S = 16'd1000;
   localparam logic [RATE_W-1:0] SAT16    = 16'hFFFF;

   // Queue between front and back.
   localparam int Q_DEPTH = 2;

   // One classified item, handed from front to back.
   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic                 mode;
      logic                 defined;   // rate is defined for this window
      logic [LEVEL_W-1:0]   dep;       // oldest level minus newest level
      logic [TIME_W-1:0]    span;      // newest time minus oldest time
      logic [LEVEL_W-1:0]   newest;    // newest level
   } bdrm_job_type;

   // Configuration registers seen by the back end.
   typedef struct packed {
      logic [RATE_W-1:0]  threshold;
      logic [LEVEL_W-1:0] critical;
   } bdrm_cfg_type;

endpackage

/* design/bdrm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bdrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/bdrm_fifo.sv */
// Short register queue carrying classified items from front to back.
module bdrm_fifo #(
   parameter int DEPTH = bdrm_pkg::Q_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bdrm_pkg::bdrm_job_type push_data,
   output logic                  full,
   input  logic                  pop,
   output bdrm_pkg::bdrm_job_type pop_data,
   output logic                  empty
);
   import bdrm_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   bdrm_job_type    entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CNTW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/bdrm_front.sv */
// Front end: accepts words, updates the sample windows, classifies the window.
module bdrm_front #(
   parameter int WINDOW       = bdrm_pkg::WINDOW_DEF,
   parameter int NUM_CHANNELS = bdrm_pkg::NUM_CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bdrm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                              req_tuser,
   output logic                              job_push,
   output bdrm_pkg::bdrm_job_type            job_data,
   input  logic                              job_full
);
   import bdrm_pkg::*;

   localparam int DEPTH   = NUM_CHANNELS * WINDOW;
   localparam int AW      = $clog2(DEPTH);
   localparam int HW      = $clog2(WINDOW);
   localparam int FW      = $clog2(WINDOW + 1);
   localparam int DW      = HW + 2;
   localparam int CW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CHX     = (CW > CHANNEL_W) ? CW : CHANNEL_W;
   localparam int ENTRY_W = TIME_W + LEVEL_W;

   localparam logic [2:0] F_IDLE  = 3'd0;
   localparam logic [2:0] F_WRITE = 3'd1;
   localparam logic [2:0] F_RDN   = 3'd2;
   localparam logic [2:0] F_RDO   = 3'd3;
   localparam logic [2:0] F_CAPO  = 3'd4;
   localparam logic [2:0] F_ENQ   = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [HW-1:0]        head_ff [NUM_CHANNELS];
   logic [FW-1:0]        fill_ff [NUM_CHANNELS];
   logic                 seen_ff;
   logic                 mode_ff;
   logic [CHANNEL_W-1:0] ch_ff;
   logic [TIME_W-1:0]    ts_ff;
   logic [LEVEL_W-1:0]   lvl_ff;
   logic [TIME_W-1:0]    new_time_ff, old_time_ff;
   logic [LEVEL_W-1:0]   new_lvl_ff, old_lvl_ff;

   logic                 accept, ch_ok, is_push;
   logic [CHX-1:0]       ch_ext;
   logic [CW-1:0]        idx;
   logic [HW-1:0]        head, head_next, newest_i, oldest_i;
   logic [FW-1:0]        fill;
   logic [DW-1:0]        oldest_sum;
   logic [AW-1:0]        base, wr_addr, rd_addr;
   logic                 wr_en;
   logic [ENTRY_W-1:0]   rd_data;
   logic [TIME_W-1:0]    span;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == F_IDLE);

   assign ch_ok   = (32'(ch_ff) < NUM_CHANNELS);
   assign is_push = (mode_ff == MODE_PUSH);
   assign ch_ext  = CHX'(ch_ff);
   assign idx     = ch_ext[CW-1:0];
   assign head    = head_ff[idx];
   assign fill    = fill_ff[idx];
   assign base    = AW'(idx) * AW'(WINDOW);

   // Ring arithmetic: newest sits just behind the head, oldest fill slots back.
   assign head_next  = (head == HW'(WINDOW - 1)) ? '0 : head + 1'b1;
   assign newest_i   = (head == '0) ? HW'(WINDOW - 1) : head - 1'b1;
   assign oldest_sum = DW'(head) + DW'(WINDOW) - DW'(fill);
   assign oldest_i   = (oldest_sum >= DW'(WINDOW)) ? HW'(oldest_sum - DW'(WINDOW))
                                                   : HW'(oldest_sum);

   assign wr_en   = (state_ff == F_WRITE) && ch_ok && is_push;
   assign wr_addr = base + AW'(head);
   assign rd_addr = base + AW'((state_ff == F_RDN) ? newest_i : oldest_i);

   bdrm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({ts_ff, lvl_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Classify: one sample gives a zero span, so it falls out as undefined too.
   assign span = new_time_ff - old_time_ff;

   always_comb begin
      job_data.channel = ch_ff;
      job_data.mode    = mode_ff;
      job_data.defined = seen_ff && (span != '0) && (old_lvl_ff > new_lvl_ff);
      job_data.dep     = old_lvl_ff - new_lvl_ff;
      job_data.span    = span;
      job_data.newest  = new_lvl_ff;
   end

   assign job_push = (state_ff == F_ENQ) && !job_full;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE:  if (accept) state_in = F_WRITE;
         F_WRITE: state_in = ch_ok ? F_RDN : F_ENQ;
         F_RDN:   state_in = (fill == '0) ? F_ENQ : F_RDO;
         F_RDO:   state_in = F_CAPO;
         F_CAPO:  state_in = F_ENQ;
         F_ENQ:   if (!job_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         seen_ff  <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (accept) begin
            seen_ff <= 1'b0;
         end else if (state_ff == F_CAPO) begin
            seen_ff <= 1'b1;
         end
         if (wr_en) begin
            head_ff[idx] <= head_next;
            if (fill < FW'(WINDOW)) begin
               fill_ff[idx] <= fill + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_tuser;
         ch_ff   <= req_tdata[CHANNEL_W-1:0];
         ts_ff   <= req_tdata[CHANNEL_W +: TIME_W];
         lvl_ff  <= req_tdata[CHANNEL_W + TIME_W +: LEVEL_W];
      end
      if (state_ff == F_RDO) begin
         {new_time_ff, new_lvl_ff} <= rd_data;
      end
      if (state_ff == F_CAPO) begin
         {old_time_ff, old_lvl_ff} <= rd_data;
      end
   end

endmodule

/* design/bdrm_back.sv */
// Back end: multiplies and divides out rate, alarm and times, drives the result.
module bdrm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_empty,
   output logic                              job_pop,
   input  bdrm_pkg::bdrm_job_type            job_data,
   input  bdrm_pkg::bdrm_cfg_type            cfg,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bdrm_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import bdrm_pkg::*;

   localparam int QBITS = RATE_W;

   localparam logic [3:0] B_IDLE  = 4'd0;
   localparam logic [3:0] B_MDEN  = 4'd1;
   localparam logic [3:0] B_MTHR  = 4'd2;
   localparam logic [3:0] B_MTTC  = 4'd3;
   localparam logic [3:0] B_MTTE  = 4'd4;
   localparam logic [3:0] B_DINIT = 4'd5;
   localparam logic [3:0] B_DRUN  = 4'd6;
   localparam logic [3:0] B_OUT   = 4'd7;

   localparam logic [1:0] PH_RATE = 2'd0;
   localparam logic [1:0] PH_TTC  = 2'd1;
   localparam logic [1:0] PH_TTE  = 2'd2;

   logic [3:0]             state_ff, state_in;
   logic [1:0]             phase_ff, phase_in;
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   bdrm_job_type           job_ff;
   logic [DEN_W-1:0]       den_ff;
   logic [PROD_W-1:0]      thr_prod_ff;
   logic [TIME_W-1:0]      div_hi_ff, div_d_ff, rem_ff;
   logic [QBITS-1:0]       div_lo_ff, q_ff;
   logic [STEP_W-1:0]      cnt_ff;
   logic [RATE_W-1:0]      rate_ff, ttc_ff, tte_ff;
   logic                   alarm_ff;

   logic [TIME_W-1:0]      mul_a;
   logic [RATE_W-1:0]      mul_b;
   logic [PROD_W-1:0]      product;
   logic [LEVEL_W-1:0]     ttc_diff;
   logic                   out_free, div_sat, div_last, div_done, div_ge;
   logic [TIME_W:0]        rem_shift;
   logic [TIME_W-1:0]      rem_next;
   logic [QBITS-1:0]       q_next, div_result;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign job_pop  = (state_ff == B_IDLE) && !job_empty;
   assign ttc_diff = (job_ff.newest > cfg.critical) ? job_ff.newest - cfg.critical : '0;

   // Shared 32 x 16 multiplier; each product lands in a register.
   always_comb begin
      case (state_ff)
         B_MDEN: begin
            mul_a = TIME_W'(job_ff.dep);
            mul_b = MS_PER_S;
         end
         B_MTHR: begin
            mul_a = job_ff.span;
            mul_b = cfg.threshold;
         end
         B_MTTC: begin
            mul_a = job_ff.span;
            mul_b = RATE_W'(ttc_diff);
         end
         B_MTTE: begin
            mul_a = job_ff.span;
            mul_b = RATE_W'(job_ff.newest);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Saturating divider: upper numerator bits at or above the divisor mean
   // the quotient cannot fit 16 bits; otherwise shift in 16 low bits.
   assign div_sat    = (div_hi_ff >= div_d_ff);
   assign rem_shift  = {rem_ff, div_lo_ff[QBITS-1]};
   assign div_ge     = (rem_shift >= {1'b0, div_d_ff});
   assign rem_next   = div_ge ? TIME_W'(rem_shift - {1'b0, div_d_ff}) : rem_shift[TIME_W-1:0];
   assign q_next     = {q_ff[QBITS-2:0], div_ge};
   assign div_last   = (state_ff == B_DRUN) && (cnt_ff == STEP_W'(1));
   assign div_done   = ((state_ff == B_DINIT) && div_sat) || div_last;
   assign div_result = (state_ff == B_DINIT) ? SAT16 : q_next;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               state_in = job_data.defined ? B_MDEN : B_OUT;
            end
         end
         B_MDEN: state_in = B_MTHR;
         B_MTHR: begin
            state_in = B_DINIT;
            phase_in = PH_RATE;
         end
         B_MTTC: begin
            state_in = B_DINIT;
            phase_in = PH_TTC;
         end
         B_MTTE: begin
            state_in = B_DINIT;
            phase_in = PH_TTE;
         end
         B_DINIT, B_DRUN: begin
            if (div_done) begin
               case (phase_ff)
                  PH_RATE: state_in = B_MTTC;
                  PH_TTC:  state_in = B_MTTE;
                  default: state_in = B_OUT;
               endcase
            end else begin
               state_in = B_DRUN;
            end
         end
         B_OUT:   if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         phase_ff     <= PH_RATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         if ((state_ff == B_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            job_ff   <= job_data;
            rate_ff  <= '0;
            ttc_ff   <= '0;
            tte_ff   <= '0;
            alarm_ff <= 1'b0;
         end
         B_MDEN: den_ff <= DEN_W'(product);
         B_MTHR: begin
            thr_prod_ff           <= product;
            {div_hi_ff, div_lo_ff} <= PROD_W'(den_ff);
            div_d_ff              <= job_ff.span;
         end
         B_MTTC, B_MTTE: begin
            {div_hi_ff, div_lo_ff} <= product;
            div_d_ff              <= TIME_W'(den_ff);
         end
         B_DINIT: begin
            rem_ff <= div_hi_ff;
            q_ff   <= '0;
            cnt_ff <= STEP_W'(QBITS);
         end
         B_DRUN: begin
            rem_ff    <= rem_next;
            q_ff      <= q_next;
            div_lo_ff <= {div_lo_ff[QBITS-2:0], 1'b0};
            cnt_ff    <= cnt_ff - 1'b1;
         end
         default: ;
      endcase

      // Exact compare: den * 256 against threshold * span, pushes only.
      if (state_ff == B_MTTC) begin
         alarm_ff <= (job_ff.mode == MODE_PUSH) &&
                     (PROD_W'({den_ff, 8'h00}) > thr_prod_ff);
      end

      if (div_done) begin
         case (phase_ff)
            PH_RATE: rate_ff <= div_result;
            PH_TTC:  ttc_ff  <= div_result;
            default: tte_ff  <= div_result;
         endcase
      end

      if ((state_ff == B_OUT) && out_free) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, tte_ff, ttc_ff, alarm_ff, rate_ff, job_ff.channel};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* design/battery_drain_rate_monitor_top.sv */
// Top level of the battery drain rate monitor: ports, registers, front, queue, back.
//
//  Channel  Direction  Handshake                Payload
//  req_     in         req_tvalid / req_tready  tdata: channel, timestamp_ms, battery_level
//                                               tuser: mode
//  rsp_     out        rsp_tvalid / rsp_tready  tdata: out_channel, drain_rate, drain_alarm,
//                                               seconds_to_critical, seconds_to_empty
//  csr_     in         csr_valid / csr_ready    csr_index, csr_data
//
//  Front: accept, store write, newest read, oldest read, capture, queue; an empty window
//  skips oldest read and capture. Back: with a defined rate, multiplies, three divisions
//  (an init step, then shift steps; the init alone when a quotient saturates), else output
//  only; the back's divider sets the sustained rate. Reset clears ring heads, fill counts,
//  queue and output valid; the sample store has no reset. A stalled result holds the
//  back, the full queue then holds the front, and req_tready drops.
module battery_drain_rate_monitor_top #(
   parameter int WINDOW       = bdrm_pkg::WINDOW_DEF,
   parameter int NUM_CHANNELS = bdrm_pkg::NUM_CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input words
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [1:0] channel, [33:2] timestamp_ms, [48:34] battery_level, rest zero
   input  logic [bdrm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] mode
   input  logic                              req_tuser,
   // Result words
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] out_channel, [17:2] drain_rate, [18] drain_alarm,
   // [34:19] seconds_to_critical, [50:35] seconds_to_empty, rest zero
   output logic [bdrm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // Configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bdrm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bdrm_pkg::CSR_DATA_W-1:0]   csr_data
);
   import bdrm_pkg::*;

   logic [RATE_W-1:0]  threshold_ff;
   logic [LEVEL_W-1:0] critical_ff;
   bdrm_cfg_type       cfg;

   bdrm_job_type       push_job, pop_job;
   logic               job_push, job_pop, job_full, job_empty;

   // Registers take a write in any cycle; indexes past the list are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RST;
         critical_ff  <= CRITICAL_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_data;
            CSR_CRITICAL:  critical_ff  <= csr_data[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.threshold = threshold_ff;
   assign cfg.critical  = critical_ff;

   // Front: accept, update the window, classify.
   bdrm_front #(
      .WINDOW       (WINDOW),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_push   (job_push),
      .job_data   (push_job),
      .job_full   (job_full)
   );

   // Queue: decouple front from back.
   bdrm_fifo #(
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (pop_job),
      .empty     (job_empty)
   );

   // Back: arithmetic and the output register.
   bdrm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_empty  (job_empty),
      .job_pop    (job_pop),
      .job_data   (pop_job),
      .cfg        (cfg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* design/bdrm_checker.sv */
// Port-level checks for the battery drain rate monitor, bound to the top level.
module bdrm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bdrm_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import bdrm_pkg::*;

   // After reset no result is pending and the input side is open.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("state after reset wrong");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Time to critical never exceeds time to empty.
   a_ttc_le_tte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[34:19] <= rsp_tdata[50:35]))
      else $error("time to critical above time to empty");

   // Padding bits of a result word stay zero.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_TDATA_W-1:RSP_FIELDS_W] == '0))
      else $error("result padding not zero");

endmodule

bind battery_drain_rate_monitor_top bdrm_checker u_checker (.*);

/* test/tb_battery_drain_rate_monitor_top.sv */
// Self-checking testbench for the battery drain rate monitor top level.
module tb_battery_drain_rate_monitor_top;
   import bdrm_pkg::*;

   localparam int HIST_DEPTH  = WINDOW_DEF;
   localparam int CHANNELS    = NUM_CHANNELS_DEF;
   localparam int LEVEL_FULL  = 25600;
   localparam int PHASES      = 5;
   localparam int PHASE_ITEMS = 170;
   localparam int CYCLE_LIMIT = 400000;
   localparam int QUIET_TAIL  = 100;

   localparam logic MODE_REPORT = ~MODE_PUSH;

   // One result word, laid out as on rsp_tdata (first member in the top bits).
   typedef struct packed {
      logic [RATE_W-1:0]    to_empty;
      logic [RATE_W-1:0]    to_critical;
      logic                 alarm;
      logic [RATE_W-1:0]    rate;
      logic [CHANNEL_W-1:0] channel;
   } drain_report_type;

   // One row of the directed table; typed rows carry their own expected report.
   typedef struct packed {
      logic                 mode;
      logic [CHANNEL_W-1:0] channel;
      logic [TIME_W-1:0]    stamp;
      logic [LEVEL_W-1:0]   level;
      logic                 typed;
      drain_report_type     report;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   battery_drain_rate_monitor_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Mirror of the block: per-channel sample rings and the two registers.
   logic [TIME_W-1:0]  hist_time  [CHANNELS][HIST_DEPTH];
   logic [LEVEL_W-1:0] hist_level [CHANNELS][HIST_DEPTH];
   int unsigned        ring_head  [CHANNELS];
   int unsigned        fill_count [CHANNELS];
   logic [RATE_W-1:0]  alarm_threshold;
   logic [LEVEL_W-1:0] critical_q8;

   drain_report_type pending_reports [$];
   stim_row_type     directed [$];
   int               mismatch_count;
   int unsigned      cycle_count;
   logic [15:0]      rx_pattern;

   function automatic logic [RATE_W-1:0] clip16(input logic [63:0] value);
      return (value > 64'(SAT16)) ? SAT16 : value[RATE_W-1:0];
   endfunction

   function automatic drain_report_type quiet_report(input logic [CHANNEL_W-1:0] ch);
      drain_report_type r;
      r         = '0;
      r.channel = ch;
      return r;
   endfunction

   // Append one row to the directed table.
   function automatic void add_row(input stim_row_type row);
      directed.insert(directed.size(), row);
   endfunction

   // Apply one word to the mirror and work out the report it produces.
   function automatic drain_report_type predict_drain_report(
      input logic                 mode,
      input logic [CHANNEL_W-1:0] ch,
      input logic [TIME_W-1:0]    stamp,
      input logic [LEVEL_W-1:0]   level
   );
      drain_report_type   r;
      int unsigned        slot;
      int unsigned        fill;
      int unsigned        newest_i;
      int unsigned        oldest_i;
      logic [TIME_W-1:0]  span;
      logic [LEVEL_W-1:0] newest;
      logic [LEVEL_W-1:0] oldest;
      logic [63:0]        den;
      r = quiet_report(ch);
      if (ch < CHANNELS) begin
         if (mode == MODE_PUSH) begin
            slot                 = ring_head[ch];
            hist_time[ch][slot]  = stamp;
            hist_level[ch][slot] = level;
            ring_head[ch]        = (slot + 1) % HIST_DEPTH;
            if (fill_count[ch] < HIST_DEPTH) fill_count[ch]++;
         end
         fill = fill_count[ch];
         // Fewer than two samples leaves the rate undefined: all zero.
         if (fill >= 2) begin
            newest_i = (ring_head[ch] + HIST_DEPTH - 1) % HIST_DEPTH;
            oldest_i = (ring_head[ch] + HIST_DEPTH - fill) % HIST_DEPTH;
            span     = hist_time[ch][newest_i] - hist_time[ch][oldest_i];
            newest   = hist_level[ch][newest_i];
            oldest   = hist_level[ch][oldest_i];
            if (span != '0 && oldest > newest) begin
               den    = 64'(oldest - newest) * 64'(MS_PER_S);
               r.rate = clip16(den / 64'(span));
               // Alarm uses the exact quotient, and only pushes raise it.
               if (mode == MODE_PUSH && den * 64'd256 > 64'(alarm_threshold) * 64'(span))
                  r.alarm = 1'b1;
               if (newest > critical_q8)
                  r.to_critical = clip16(64'(newest - critical_q8) * 64'(span) / den);
               r.to_empty = clip16(64'(newest) * 64'(span) / den);
            end
         end
      end
      return r;
   endfunction

   // Offer one word, hold it until accepted, then queue its expected report.
   task automatic send_word(
      input logic                 mode,
      input logic [CHANNEL_W-1:0] ch,
      input logic [TIME_W-1:0]    stamp,
      input logic [LEVEL_W-1:0]   level,
      input logic                 typed,
      input drain_report_type     typed_report
   );
      drain_report_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(REQ_TDATA_W - REQ_FIELDS_W){1'b0}}, level, stamp, ch};
      do @(posedge clock); while (!req_tready);
      predicted = predict_drain_report(mode, ch, stamp, level);
      pending_reports.insert(pending_reports.size(), typed ? typed_report : predicted);
   endtask

   // Drop valid for a gap, optionally until every queued report has come back.
   task automatic idle_sender(input int gap, input bit drain);
      if (gap > 0 || drain) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         while (drain && pending_reports.size() != 0) @(posedge clock);
      end
   endtask

   // Write one register; the caller drops csr_valid after the last write.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_THRESHOLD) alarm_threshold = value;
      else if (index == CSR_CRITICAL) critical_q8 = value[LEVEL_W-1:0];
   endtask

   // Result side: stall on a 16-bit ready pattern that each phase picks.
   initial begin
      logic [3:0] rx_slot;
      rsp_tready = 1'b0;
      rx_slot    = '0;
      forever begin
         @(posedge clock);
         rsp_tready <= rx_pattern[rx_slot];
         rx_slot++;
      end
   end

   // Check every accepted result against the oldest expected report.
   always @(posedge clock) begin
      drain_report_type seen;
      drain_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = drain_report_type'(rsp_tdata[RSP_FIELDS_W-1:0]);
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word: ch %0d rate %0d alarm %0d ttc %0d tte %0d",
                        seen.channel, seen.rate, seen.alarm, seen.to_critical,
                        seen.to_empty);
         end else begin
            want = pending_reports[0];
            pending_reports.delete(0);
            if (seen.channel != want.channel || seen.rate != want.rate ||
                seen.alarm != want.alarm || seen.to_critical != want.to_critical ||
                seen.to_empty != want.to_empty) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"result mismatch: expected ch %0d rate %0d alarm %0d ttc %0d ",
                            "tte %0d, got ch %0d rate %0d alarm %0d ttc %0d tte %0d"},
                           want.channel, want.rate, want.alarm, want.to_critical,
                           want.to_empty, seen.channel, seen.rate, seen.alarm,
                           seen.to_critical, seen.to_empty);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_battery_drain_rate_monitor_top: errors");
         $finish;
      end
   end

   initial begin
      stim_row_type         row;
      drain_report_type     saturated;
      logic [RATE_W-1:0]    phase_threshold [PHASES];
      logic [LEVEL_W-1:0]   phase_critical  [PHASES];
      logic [15:0]          phase_rx        [PHASES];
      logic [TIME_W-1:0]    last_time  [CHANNELS];
      logic [LEVEL_W-1:0]   last_level [CHANNELS];
      logic                 mode;
      logic [CHANNEL_W-1:0] ch;
      logic [TIME_W-1:0]    stamp;
      logic [LEVEL_W-1:0]   level;
      int                   pick;
      int                   drop;
      int                   burst_left;
      bit                   sender_idles;

      // Every input known from time zero; reset held at the start, then released.
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      rx_pattern     = 16'hFFFF;
      cycle_count    = 0;
      mismatch_count = 0;
      for (int c = 0; c < CHANNELS; c++) begin
         ring_head[c]  = 0;
         fill_count[c] = 0;
         last_time[c]  = $urandom;
         last_level[c] = LEVEL_W'(LEVEL_FULL);
      end
      alarm_threshold = THRESHOLD_RST;
      critical_q8     = CRITICAL_RST;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table, run on the reset register values.
      saturated = '{channel: 2'd3, rate: '0, alarm: 1'b0,
                    to_critical: SAT16, to_empty: SAT16};
      // empty windows report all zero, whatever the word carries
      add_row('{MODE_REPORT, 2'd0, 32'd0, 15'd0, 1'b1, quiet_report(2'd0)});
      add_row('{MODE_REPORT, 2'd3, 32'hFFFF_FFFF, 15'd25600, 1'b1, quiet_report(2'd3)});
      // one sample, then a second at the same time: no span
      add_row('{MODE_PUSH, 2'd0, 32'd0, 15'd25600, 1'b1, quiet_report(2'd0)});
      add_row('{MODE_PUSH, 2'd0, 32'd0, 15'd25000, 1'b1, quiet_report(2'd0)});
      add_row('{MODE_PUSH, 2'd0, 32'd1000, 15'd24000, 1'b0, '0});
      add_row('{MODE_REPORT, 2'd0, 32'd5, 15'd5, 1'b0, '0});
      // a rising level means no depletion; then drain to an empty battery
      add_row('{MODE_PUSH, 2'd1, 32'd100, 15'd100, 1'b1, quiet_report(2'd1)});
      add_row('{MODE_PUSH, 2'd1, 32'd200, 15'd200, 1'b1, quiet_report(2'd1)});
      add_row('{MODE_PUSH, 2'd1, 32'd300, 15'd0, 1'b0, '0});
      // timestamp wraps past 2^32 over a short span: rate saturates
      add_row('{MODE_PUSH, 2'd2, 32'hFFFF_FF00, 15'd25600, 1'b1, quiet_report(2'd2)});
      add_row('{MODE_PUSH, 2'd2, 32'h0000_0010, 15'd0, 1'b0, '0});
      // widest span with the smallest drop: rate 0 but both times saturate
      add_row('{MODE_PUSH, 2'd3, 32'd0, 15'd25600, 1'b1, quiet_report(2'd3)});
      add_row('{MODE_PUSH, 2'd3, 32'hFFFF_FFFF, 15'd25599, 1'b1, saturated});
      add_row('{MODE_PUSH, 2'd3, 32'hFFFF_FFFF, 15'd25599, 1'b0, '0});
      // overrun channel 0's window so the ring wraps and the oldest drops
      for (int k = 0; k < HIST_DEPTH; k++)
         add_row('{MODE_PUSH, 2'd0, 32'(2000 + k * 500), 15'(23000 - k * 700), 1'b0, '0});

      foreach (directed[i]) begin
         row = directed[i];
         send_word(row.mode, row.channel, row.stamp, row.level, row.typed, row.report);
         idle_sender($urandom_range(0, 3), 1'b0);
      end
      idle_sender(0, 1'b1);

      // Register settings per phase, extremes included.
      phase_threshold = '{THRESHOLD_RST, 16'd0, 16'hFFFF, 16'd1000,
                          RATE_W'($urandom)};
      phase_critical  = '{CRITICAL_RST, 15'd0, 15'd25600, 15'd12345,
                          LEVEL_W'($urandom_range(0, LEVEL_FULL))};
      phase_rx        = '{16'hFFFF, 16'($urandom) | 16'h0001, 16'h00FF, 16'h0001,
                          16'($urandom) | 16'h8000};

      for (int p = 0; p < PHASES; p++) begin
         // Sender is idle and every report is back: safe to write registers.
         write_register(CSR_THRESHOLD, phase_threshold[p]);
         write_register(CSR_CRITICAL, CSR_DATA_W'(phase_critical[p]));
         csr_valid    <= 1'b0;
         rx_pattern   = phase_rx[p];
         sender_idles = (p != 0);
         burst_left   = $urandom_range(1, 24);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            ch   = CHANNEL_W'($urandom_range(0, CHANNELS - 1));
            if (pick < 15) begin
               // report only: time and level ride along and are ignored
               mode  = MODE_REPORT;
               stamp = $urandom;
               level = LEVEL_W'($urandom_range(0, LEVEL_FULL));
            end else if (pick < 28) begin
               // noise: any time, any level
               mode  = MODE_PUSH;
               stamp = $urandom;
               level = LEVEL_W'($urandom_range(0, LEVEL_FULL));
            end else if (pick < 33) begin
               // repeated timestamp
               mode  = MODE_PUSH;
               stamp = last_time[ch];
               level = last_level[ch];
            end else begin
               // steady discharge with a spread of sample spacings
               mode = MODE_PUSH;
               case ($urandom_range(0, 9))
                  0, 1:    stamp = last_time[ch] + $urandom_range(1, 20);
                  2, 3, 4, 5, 6:
                           stamp = last_time[ch] + $urandom_range(200, 3000);
                  7, 8:    stamp = last_time[ch] + $urandom_range(5000, 60000);
                  default: stamp = last_time[ch] + $urandom_range(1, 32'h7FFF_FFFF);
               endcase
               drop = $urandom_range(0, 400);
               if ($urandom_range(0, 19) == 0)
                  level = LEVEL_W'($urandom_range(20000, LEVEL_FULL));
               else
                  level = (last_level[ch] > drop) ? LEVEL_W'(last_level[ch] - drop) : '0;
            end
            if (mode == MODE_PUSH) begin
               last_time[ch]  = stamp;
               last_level[ch] = level;
            end
            send_word(mode, ch, stamp, level, 1'b0, '0);
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               idle_sender(sender_idles ? $urandom_range(0, 8) : 0,
                           $urandom_range(0, 59) == 0);
            end
         end
         idle_sender(0, 1'b1);
      end

      // Let any stray word surface before the verdict.
      idle_sender(0, 1'b1);
      repeat (QUIET_TAIL) @(posedge clock);
      if (pending_reports.size() != 0) mismatch_count++;
      if (mismatch_count == 0)
         $display("tb_battery_drain_rate_monitor_top: clean");
      else
         $display("tb_battery_drain_rate_monitor_top: errors");
      $finish;
   end

endmodule

/* filelist.f */
design/bdrm_pkg.sv
design/bdrm_ram.sv
design/bdrm_fifo.sv
design/bdrm_front.sv
design/bdrm_back.sv
design/battery_drain_rate_monitor_top.sv
design/bdrm_checker.sv
test/tb_battery_drain_rate_monitor_top.sv
